/* rtl/cnf_clause_normalizer_unit_assert.svh */
// Assertion macros shared by the clause normaliser RTL.
`ifndef CNF_CLAUSE_NORMALIZER_UNIT_ASSERT_SVH
`define CNF_CLAUSE_NORMALIZER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CNFCN_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cnfcn: check failed");

// Next-cycle implication, disabled during reset.
`define CNFCN_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cnfcn: check failed");

`endif

/* rtl/cnfcn_pkg.sv */
// Shared constants, verdict codes and the probe beat type of the clause normaliser.
package cnfcn_pkg;

   localparam int unsigned LitWidth       = 21;
   localparam int unsigned VarWidth       = 20;
   localparam int unsigned CountWidth     = 7;
   localparam int unsigned IndexWidth     = 32;
   localparam int unsigned MaxLitsDefault = 64;

   typedef enum logic [2:0] {
      V_PENDING  = 3'd0,
      V_ACCEPTED = 3'd1,
      V_BAD      = 3'd2,
      V_TAUT     = 3'd3,
      V_EMPTY    = 3'd4,
      V_LONG     = 3'd5
   } verdict_type;

   // Probe walking the cell chain: the literal, its negation and the flags gathered so far.
   typedef struct packed {
      logic                active;
      logic [LitWidth-1:0] lit;
      logic [LitWidth-1:0] lit_neg;
      logic                same;
      logic                comp;
   } probe_type;

endpackage

/* rtl/cnfcn_cell.sv */
// One cell of the compare chain: holds one kept literal and checks the passing probe.
module cnfcn_cell import cnfcn_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  probe_type           probe_in,
   input  logic                live,
   input  logic                wr_en,
   input  logic [LitWidth-1:0] wr_lit,
   output probe_type           probe_out
);

   logic [LitWidth-1:0] stored_ff;
   probe_type           probe_ff;
   probe_type           probe_in_upd;

   always_comb begin
      probe_in_upd      = probe_in;
      probe_in_upd.same = probe_in.same | (live && (stored_ff == probe_in.lit));
      probe_in_upd.comp = probe_in.comp | (live && (stored_ff == probe_in.lit_neg));
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stored_ff <= wr_lit;
      end
   end

   // Advance the probe one cell per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in_upd;
      end
   end

   assign probe_out = probe_ff;

endmodule

/* rtl/cnf_clause_normalizer_unit.sv */
// Clause normaliser: literals (zero ends a clause) in, one result beat per literal out. A
// terminator, a literal after the clause has failed, or an out-of-range literal gives its
// result in the cycle after acceptance. Any other literal is checked by a probe that walks
// the chain of MAX_LITS cells, one cell per cycle, and its result beat is registered as the
// probe leaves the last cell. One literal is in work at a time, and the next is taken in the
// same cycle the pending result beat leaves.
module cnf_clause_normalizer_unit import cnfcn_pkg::*; #(
   parameter int unsigned MAX_LITS = MaxLitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [VarWidth-1:0]   csr_var_count,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [LitWidth-1:0]   req_literal,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [LitWidth-1:0]   rsp_literal_out,
   output logic                  rsp_keep,
   output logic                  rsp_clause_done,
   output logic [2:0]            rsp_verdict,
   output logic [CountWidth-1:0] rsp_kept_count,
   output logic [IndexWidth-1:0] rsp_clause_index
);

`include "cnf_clause_normalizer_unit_assert.svh"

   localparam int unsigned KW = $clog2(MAX_LITS + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_OUT  = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [VarWidth-1:0]   var_count_ff;
   logic [KW-1:0]         kept_total_ff, kept_total_in;
   verdict_type           clause_error_ff, clause_error_in;
   logic [IndexWidth-1:0] accepted_ff, accepted_in;
   logic [LitWidth-1:0]   lit_hold_ff, lit_hold_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LitWidth-1:0]   rsp_lit_ff, rsp_lit_in;
   logic                  rsp_keep_ff, rsp_keep_in;
   logic                  rsp_done_ff, rsp_done_in;
   verdict_type           rsp_verdict_ff, rsp_verdict_in;
   logic [CountWidth-1:0] rsp_count_ff, rsp_count_in;
   logic [IndexWidth-1:0] rsp_index_ff, rsp_index_in;

   probe_type             chain [0:MAX_LITS];
   probe_type             probe_head;
   logic                  store_en;
   logic                  take;
   logic [LitWidth-1:0]   lit_neg;
   logic [LitWidth-1:0]   mag;
   logic                  bad;
   logic                  is_term;

   function automatic logic [CountWidth-1:0] to_count(input logic [KW-1:0] v);
      logic [KW+CountWidth-1:0] wide;
      wide = {{CountWidth{1'b0}}, v};
      return wide[CountWidth-1:0];
   endfunction

   assign csr_ready = 1'b1;
   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_OUT) && !rsp_stall));
   assign take      = req_valid && !req_stall;
   assign lit_neg   = LitWidth'(-req_literal);
   assign mag       = req_literal[LitWidth-1] ? lit_neg : req_literal;
   assign bad       = mag > {1'b0, var_count_ff};
   assign is_term   = (req_literal == '0);

   always_comb begin
      state_in        = state_ff;
      kept_total_in   = kept_total_ff;
      clause_error_in = clause_error_ff;
      accepted_in     = accepted_ff;
      lit_hold_in     = lit_hold_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_lit_in      = rsp_lit_ff;
      rsp_keep_in     = rsp_keep_ff;
      rsp_done_in     = rsp_done_ff;
      rsp_verdict_in  = rsp_verdict_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_index_in    = rsp_index_ff;
      store_en        = 1'b0;
      probe_head      = '0;

      case (state_ff)
         ST_IDLE, ST_OUT: begin
            if ((state_ff == ST_OUT) && !rsp_stall) begin
               state_in = ST_IDLE;
            end
            if (take) begin
               rsp_lit_in     = req_literal;
               rsp_keep_in    = 1'b0;
               rsp_done_in    = 1'b0;
               rsp_verdict_in = V_PENDING;
               rsp_count_in   = to_count(kept_total_ff);
               rsp_index_in   = '0;
               if (is_term) begin
                  rsp_done_in     = 1'b1;
                  rsp_valid_in    = 1'b1;
                  state_in        = ST_OUT;
                  kept_total_in   = '0;
                  clause_error_in = V_PENDING;
                  if (clause_error_ff != V_PENDING) begin
                     rsp_verdict_in = clause_error_ff;
                  end else if (kept_total_ff == '0) begin
                     rsp_verdict_in = V_EMPTY;
                  end else begin
                     rsp_verdict_in = V_ACCEPTED;
                     rsp_index_in   = accepted_ff;
                     accepted_in    = accepted_ff + 1'b1;
                  end
               end else if (clause_error_ff != V_PENDING) begin
                  // Clause already failed: ignore the literal.
                  rsp_valid_in = 1'b1;
                  state_in     = ST_OUT;
               end else if (bad) begin
                  clause_error_in = V_BAD;
                  rsp_valid_in    = 1'b1;
                  state_in        = ST_OUT;
               end else begin
                  probe_head.active  = 1'b1;
                  probe_head.lit     = req_literal;
                  probe_head.lit_neg = lit_neg;
                  lit_hold_in        = req_literal;
                  state_in           = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (chain[MAX_LITS].active) begin
               rsp_lit_in     = lit_hold_ff;
               rsp_keep_in    = 1'b0;
               rsp_done_in    = 1'b0;
               rsp_verdict_in = V_PENDING;
               rsp_index_in   = '0;
               rsp_count_in   = to_count(kept_total_ff);
               rsp_valid_in   = 1'b1;
               state_in       = ST_OUT;
               if (chain[MAX_LITS].comp) begin
                  clause_error_in = V_TAUT;
               end else if (!chain[MAX_LITS].same) begin
                  if (kept_total_ff == KW'(MAX_LITS)) begin
                     clause_error_in = V_LONG;
                  end else begin
                     store_en      = 1'b1;
                     kept_total_in = kept_total_ff + 1'b1;
                     rsp_keep_in   = 1'b1;
                     rsp_count_in  = to_count(kept_total_ff + 1'b1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign chain[0] = probe_head;

   for (genvar i = 0; i < MAX_LITS; i++) begin : g_cell
      cnfcn_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .probe_in  (chain[i]),
         .live      (KW'(i) < kept_total_ff),
         .wr_en     (store_en && (kept_total_ff == KW'(i))),
         .wr_lit    (lit_hold_ff),
         .probe_out (chain[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         var_count_ff    <= VarWidth'(1);
         kept_total_ff   <= '0;
         clause_error_ff <= V_PENDING;
         accepted_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         kept_total_ff   <= kept_total_in;
         clause_error_ff <= clause_error_in;
         accepted_ff     <= accepted_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            var_count_ff <= csr_var_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      lit_hold_ff    <= lit_hold_in;
      rsp_lit_ff     <= rsp_lit_in;
      rsp_keep_ff    <= rsp_keep_in;
      rsp_done_ff    <= rsp_done_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_index_ff   <= rsp_index_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_literal_out  = rsp_lit_ff;
   assign rsp_keep         = rsp_keep_ff;
   assign rsp_clause_done  = rsp_done_ff;
   assign rsp_verdict      = rsp_verdict_ff;
   assign rsp_kept_count   = rsp_count_ff;
   assign rsp_clause_index = rsp_index_ff;

   `CNFCN_ASSERT_IMP(a_probe_exit_in_scan, clock, reset, chain[MAX_LITS].active, state_ff == ST_SCAN)
   `CNFCN_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, kept_total_ff <= KW'(MAX_LITS))
   `CNFCN_ASSERT_IMP(a_index_accepted_only, clock, reset, rsp_valid && (rsp_verdict != V_ACCEPTED), rsp_clause_index == '0)
   `CNFCN_ASSERT_NXT(a_term_clears, clock, reset, take && is_term, (kept_total_ff == '0) && (clause_error_ff == V_PENDING))

endmodule
